### rtl/edt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edt_pkg
// shared types, constants and the month length function of the epoch seconds
// to date converter
// ----------------------------------------------------------------------------
package edt_pkg;

	localparam int unsigned SecsPerDay      = 86400;
	localparam int unsigned SecsPerYear     = 365 * SecsPerDay;
	localparam int unsigned SecsPerLeapYear = 366 * SecsPerDay;

	localparam logic [11:0] EpochYear  = 12'd1970;
	localparam logic [11:0] NoLeapYear = 12'd2100; // only century year in range that is not leap
	localparam logic [3:0]  LastMonth  = 4'd12;

	typedef logic [2:0] pc_t;

	localparam pc_t PC_LOAD  = 3'd0;
	localparam pc_t PC_YEAR  = 3'd1;
	localparam pc_t PC_MONTH = 3'd2;
	localparam pc_t PC_DAY   = 3'd3;
	localparam pc_t PC_EMIT  = 3'd4;

	typedef enum logic [1:0] {
		COND_IN_VALID,
		COND_FITS,
		COND_OUT_FREE
	} cond_t;

	typedef enum logic [1:0] {
		ACT_LOAD,
		ACT_SUB,
		ACT_EMIT
	} act_t;

	typedef enum logic [1:0] {
		LEN_YEAR,
		LEN_MONTH,
		LEN_DAY
	} len_sel_t;

	// one control word: when cond holds, do act and go to jump_pc, else go to next_pc
	typedef struct packed {
		cond_t    cond;
		act_t     act;
		len_sel_t len_sel;
		pc_t      jump_pc;
		pc_t      next_pc;
	} ctl_t;

	// datapath controls from the sequencer
	typedef struct packed {
		logic     load;
		logic     step;
		len_sel_t len_sel;
	} dp_ctl_t;

	// seconds in a month, february by the leap flag
	function automatic logic [31:0] month_secs(input logic [3:0] month, input logic leap);
		logic [4:0] days;
		case (month)
			4'd2:                    days = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
			default:                 days = 5'd31;
		endcase
		return 32'(days) * 32'(SecsPerDay);
	endfunction

endpackage
`default_nettype wire

### rtl/edt_ucode_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edt_ucode_rom
// control store of the converter, one control word per program step
// ----------------------------------------------------------------------------
module edt_ucode_rom (
	input  wire  edt_pkg::pc_t  pc,
	output edt_pkg::ctl_t       ctl
);
	import edt_pkg::*;

	always_comb begin
		case (pc)
			// wait for an item, load remainder and counters
			PC_LOAD:  ctl = '{COND_IN_VALID, ACT_LOAD, LEN_DAY, PC_YEAR, PC_LOAD};
			// take away whole years
			PC_YEAR:  ctl = '{COND_FITS, ACT_SUB, LEN_YEAR, PC_YEAR, PC_MONTH};
			// take away whole months
			PC_MONTH: ctl = '{COND_FITS, ACT_SUB, LEN_MONTH, PC_MONTH, PC_DAY};
			// take away whole days
			PC_DAY:   ctl = '{COND_FITS, ACT_SUB, LEN_DAY, PC_DAY, PC_EMIT};
			// hand the date to the output register once it is free
			PC_EMIT:  ctl = '{COND_OUT_FREE, ACT_EMIT, LEN_DAY, PC_LOAD, PC_EMIT};
			default:  ctl = '{COND_IN_VALID, ACT_LOAD, LEN_DAY, PC_YEAR, PC_LOAD};
		endcase
	end

endmodule
`default_nettype wire

### rtl/edt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edt_datapath
// remainder register with one subtractor, and year, month and day counters
// ----------------------------------------------------------------------------
module edt_datapath (
	input  wire              clk,
	input  wire  edt_pkg::dp_ctl_t dp_ctl,
	input  wire  [31:0]      epoch_seconds,
	output logic             fits,
	output logic [11:0]      year_cnt,
	output logic [3:0]       month_cnt,
	output logic [4:0]       day_cnt
);
	import edt_pkg::*;

	logic [31:0] rem_q;
	logic [11:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic        leap;
	logic [31:0] len;
	logic [32:0] diff;

	// 2000 is leap by the 400 rule, 2100 is the only exception in range
	assign leap = (year_q[1:0] == 2'b00) && (year_q != NoLeapYear);

	always_comb begin
		case (dp_ctl.len_sel)
			LEN_YEAR:  len = leap ? 32'(SecsPerLeapYear) : 32'(SecsPerYear);
			LEN_MONTH: len = month_secs(month_q, leap);
			default:   len = 32'(SecsPerDay);
		endcase
	end

	assign diff = {1'b0, rem_q} - {1'b0, len};
	assign fits = !diff[32] && !(dp_ctl.len_sel == LEN_MONTH && month_q == LastMonth);

	always_ff @(posedge clk) begin
		if (dp_ctl.load) begin
			rem_q   <= epoch_seconds;
			year_q  <= EpochYear;
			month_q <= 4'd1;
			day_q   <= 5'd1;
		end else if (dp_ctl.step && fits) begin
			rem_q <= diff[31:0];
			case (dp_ctl.len_sel)
				LEN_YEAR:  year_q  <= year_q + 12'd1;
				LEN_MONTH: month_q <= month_q + 4'd1;
				default:   day_q   <= day_q + 5'd1;
			endcase
		end
	end

	assign year_cnt  = year_q;
	assign month_cnt = month_q;
	assign day_cnt   = day_q;

endmodule
`default_nettype wire

### rtl/epoch_seconds_to_date.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_seconds_to_date
// unix seconds to gregorian year, month and day, run by a microcoded sequencer
// ----------------------------------------------------------------------------
//
// channel  direction  handshake            payload
// in       input      in_valid / in_ready   epoch_seconds[31:0]
// out      output     out_valid / out_ready year[11:0], month[3:0], day_of_month[4:0]
//
// one item: a load step, a step per whole year plus one, per whole month plus one,
// per whole day plus one, and an emit step
// reset clears the step counter and the output valid flag, nothing else
// in_ready is high only on the load step; the next item is taken while the
// previous date still waits in the output register
// the emit step holds while the output register is full and not being taken
//
module epoch_seconds_to_date (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [31:0] epoch_seconds,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month
);
	import edt_pkg::*;

	pc_t         pc_q;
	ctl_t        ctl;
	dp_ctl_t     dp_ctl;
	logic        fits;
	logic        cond_true;
	logic        out_free;
	logic [11:0] year_cnt;
	logic [3:0]  month_cnt;
	logic [4:0]  day_cnt;
	logic        out_valid_q;
	logic [11:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;

	edt_ucode_rom u_rom (
		.pc  (pc_q),
		.ctl (ctl)
	);

	// output slot can take a date if empty or emptied this cycle
	assign out_free = !out_valid_q || out_ready;

	// branch condition of the current control word
	always_comb begin
		case (ctl.cond)
			COND_IN_VALID: cond_true = in_valid;
			COND_FITS:     cond_true = fits;
			COND_OUT_FREE: cond_true = out_free;
			default:       cond_true = 1'b0;
		endcase
	end

	assign dp_ctl.load    = (ctl.act == ACT_LOAD) && cond_true;
	assign dp_ctl.step    = (ctl.act == ACT_SUB);
	assign dp_ctl.len_sel = ctl.len_sel;

	assign in_ready = (ctl.cond == COND_IN_VALID);

	edt_datapath u_dp (
		.clk           (clk),
		.dp_ctl        (dp_ctl),
		.epoch_seconds (epoch_seconds),
		.fits          (fits),
		.year_cnt      (year_cnt),
		.month_cnt     (month_cnt),
		.day_cnt       (day_cnt)
	);

	// step counter: conditional jump or fall to the next step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_LOAD;
		end else begin
			pc_q <= cond_true ? ctl.jump_pc : ctl.next_pc;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.act == ACT_EMIT && cond_true) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.act == ACT_EMIT && cond_true) begin
			year_q  <= year_cnt;
			month_q <= month_cnt;
			day_q   <= day_cnt;
		end
	end

	assign out_valid    = out_valid_q;
	assign year         = year_q;
	assign month        = month_q;
	assign day_of_month = day_q;

	// an accepted item starts the year loop
	a_accept_starts_years: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (pc_q == PC_YEAR))
		else $error("accepted item did not start the year loop");

	// a completed emit step always leaves a valid date behind
	a_emit_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == PC_EMIT && out_free) |=> (out_valid && pc_q == PC_LOAD))
		else $error("emit step did not fill the output register");

	// a delivered date is within the calendar ranges
	a_date_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
			&& year >= 12'd1970 && year <= 12'd2106))
		else $error("date out of range");

endmodule
`default_nettype wire

### tb/sv/tb_epoch_seconds_to_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_date
// self-checking bench for the unix seconds to gregorian date converter: a
// directed set of calendar corners, then random second counts biased toward
// year, month and day edges, run under four mixes of sender idling and
// receiver stalling; every date is checked against a local calendar model
// ----------------------------------------------------------------------------

package tb_date_pkg;

	localparam int unsigned DAY_SECS   = 86400;
	localparam int unsigned FIRST_YEAR = 1970;

	typedef struct {
		logic [31:0] seconds;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
	} calendar_date_t;

	function automatic bit leap_year(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
		case (m)
			2:           return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	function automatic longint unsigned year_span(input int unsigned y);
		return longint'(leap_year(y) ? 366 : 365) * DAY_SECS;
	endfunction

	// walk whole years, then whole months, the rest is whole days
	function automatic calendar_date_t date_of_seconds(input logic [31:0] secs);
		calendar_date_t  d;
		longint unsigned rest;
		longint unsigned span;
		int unsigned     y;
		int unsigned     m;
		bit              leap;
		rest = secs;
		y    = FIRST_YEAR;
		span = year_span(y);
		while (rest >= span) begin
			rest -= span;
			y++;
			span = year_span(y);
		end
		leap = leap_year(y);
		m    = 1;
		span = longint'(days_in_month(m, leap)) * DAY_SECS;
		while (m < 12 && rest >= span) begin
			rest -= span;
			m++;
			span = longint'(days_in_month(m, leap)) * DAY_SECS;
		end
		d.seconds      = secs;
		d.year         = 12'(y);
		d.month        = 4'(m);
		d.day_of_month = 5'(1 + rest / DAY_SECS);
		return d;
	endfunction

	// first second of a date, wrapped to 32 bits past 2106
	function automatic logic [31:0] seconds_at_date(input int unsigned y, input int unsigned m,
			input int unsigned d);
		longint unsigned total;
		total = 0;
		for (int unsigned yy = FIRST_YEAR; yy < y; yy++)
			total += year_span(yy);
		for (int unsigned mm = 1; mm < m; mm++)
			total += longint'(days_in_month(mm, leap_year(y))) * DAY_SECS;
		total += longint'(d - 1) * DAY_SECS;
		return 32'(total);
	endfunction

	class date_scoreboard;
		calendar_date_t awaited[$];
		int unsigned    taken;
		int unsigned    matched;
		int unsigned    mismatches;

		function void note_seconds(input logic [31:0] secs);
			awaited.push_back(date_of_seconds(secs));
			taken++;
		endfunction

		function void check_date(input logic [11:0] y, input logic [3:0] m, input logic [4:0] d);
			calendar_date_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("error: date %0d-%0d-%0d arrived with nothing pending", y, m, d);
				return;
			end
			want = awaited.pop_front();
			if (want.year !== y || want.month !== m || want.day_of_month !== d) begin
				mismatches++;
				if (mismatches <= 10)
					$display("error: seconds %0d expected %0d-%0d-%0d got %0d-%0d-%0d",
						want.seconds, want.year, want.month, want.day_of_month, y, m, d);
			end else begin
				matched++;
			end
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction
	endclass

endpackage

module tb_epoch_seconds_to_date;
	import tb_date_pkg::*;

	// the limit allows the conversion of every item plus long gaps and
	// stalls several times over
	localparam int unsigned CYCLE_LIMIT     = 1_000_000;
	localparam int unsigned DRAIN_CYCLES    = 200;
	localparam int unsigned HOLD_CYCLES     = 1500;
	localparam int unsigned ITEMS_PER_PHASE = 180;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic [31:0] epoch_seconds = '0;
	logic        out_valid;
	logic        out_ready     = 1'b0;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;

	// idling mix of the current phase, in percent of cycles
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	// cycles left in a forced output hold, counted down by the receiver
	int unsigned recv_hold_left = 0;
	int unsigned cycle_count    = 0;

	date_scoreboard dates = new();

	epoch_seconds_to_date dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.epoch_seconds(epoch_seconds),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles with %0d dates pending", cycle_count,
			dates.pending());
		$display("FAILURE");
		$finish;
	end

	// receiver: checks the date taken at this edge, then picks ready for the
	// next one; a forced hold keeps ready low so the block backs up into its input
	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				dates.check_date(year, month, day_of_month);
			if (recv_hold_left > 0) begin
				recv_hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// one item: optional idle cycles with valid low, then offer it and hold
	// it steady until the block takes it; valid is left high for the caller
	task automatic send_seconds(input logic [31:0] secs);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		epoch_seconds <= secs;
		do @(posedge clk); while (!in_ready);
		dates.note_seconds(secs);
	endtask

	// sender pause until every date has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (dates.pending() != 0);
	endtask

	// random second count: part uniform over 32 bits, most near a year, month
	// or day edge of a random date, the rest in the first few years
	function automatic logic [31:0] pick_seconds();
		int unsigned y;
		int unsigned m;
		int unsigned d;
		int unsigned last;
		logic [31:0] base;
		if ($urandom_range(99) < 35)
			return $urandom();
		if ($urandom_range(9) == 0)
			return $urandom_range(4 * 366 * DAY_SECS);
		y    = $urandom_range(2106, FIRST_YEAR);
		m    = $urandom_range(12, 1);
		last = days_in_month(m, leap_year(y));
		case ($urandom_range(2))
			0:       d = 1;
			1:       d = last;
			default: d = $urandom_range(last, 1);
		endcase
		base = seconds_at_date(y, m, d);
		case ($urandom_range(3))
			0:       return base - 1;
			1:       return base;
			2:       return base + DAY_SECS - 1;
			default: return base + $urandom_range(DAY_SECS - 1);
		endcase
	endfunction

	// calendar corners: epoch, first day edge, first year edge, leap february
	// in an ordinary leap year and in 2000, the non-leap century 2100, the
	// last second of a leap year, bit patterns and the top of the range
	task automatic send_directed();
		logic [31:0] picks[$];
		picks.push_back(32'd0);
		picks.push_back(32'd1);
		picks.push_back(DAY_SECS - 1);
		picks.push_back(DAY_SECS);
		picks.push_back(seconds_at_date(1971, 1, 1) - 1);
		picks.push_back(seconds_at_date(1971, 1, 1));
		picks.push_back(seconds_at_date(1972, 2, 29));
		picks.push_back(seconds_at_date(1972, 3, 1) - 1);
		picks.push_back(seconds_at_date(1972, 3, 1));
		picks.push_back(seconds_at_date(1973, 1, 1) - 1);
		picks.push_back(seconds_at_date(1973, 3, 1) - 1);
		picks.push_back(seconds_at_date(1973, 3, 1));
		picks.push_back(seconds_at_date(2000, 2, 29));
		picks.push_back(seconds_at_date(2000, 12, 31));
		picks.push_back(seconds_at_date(2100, 3, 1) - 1);
		picks.push_back(seconds_at_date(2100, 3, 1));
		picks.push_back(seconds_at_date(2101, 1, 1) - 1);
		picks.push_back(seconds_at_date(2038, 1, 19));
		picks.push_back(32'h7FFF_FFFF);
		picks.push_back(32'h8000_0000);
		picks.push_back(32'hAAAA_AAAA);
		picks.push_back(32'h5555_5555);
		picks.push_back(32'hFFFF_FFFE);
		picks.push_back(32'hFFFF_FFFF);
		foreach (picks[i])
			send_seconds(picks[i]);
	endtask

	initial begin
		int unsigned phase;
		int unsigned n;
		// reset held low from the start, released on a rising edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_directed();
		wait_drained();

		// phases: no idling, sender idle, receiver stalling, both
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				// long output hold while items keep coming: block fills and stalls in
				if (phase == 0 && n == ITEMS_PER_PHASE / 2)
					recv_hold_left = HOLD_CYCLES;
				send_seconds(pick_seconds());
			end
		end
		in_valid <= 1'b0;

		// every date back, then a quiet stretch to catch stray results
		while (dates.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d second counts converted, %0d dates matched, %0d mismatches, %0d cycles",
			dates.taken, dates.matched, dates.mismatches, cycle_count);
		$display("covered leap and century years, period edges, range ends, idle/stall mixes");
		if (dates.mismatches == 0 && dates.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
